// File: rtl/core/ist_pkg.sv
// Shared types, codes and helpers for the interval set table.
package ist_pkg;

   localparam int MAX_INTERVALS_DEF = 32;

   typedef logic signed [31:0] time_type;

   typedef struct packed {
      time_type s;
      time_type e;
   } entry_type;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_FIND   = 3'd2,
      OP_SHIFT  = 3'd3,
      OP_LOWER  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_EVAL2,
      ST_FLUSH,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_BEFORE,
      PH_MERGE,
      PH_AFTER
   } phase_type;

   localparam time_type NONE_START = 32'sh0001_0000;
   localparam time_type NONE_END   = 32'shFFFF_0000;

   // a - b, clamped to the signed 32-bit range
   function automatic time_type sat_sub(time_type a, time_type b);
      logic signed [32:0] diff;
      diff = {a[31], a} - {b[31], b};
      if (diff[32] != diff[31]) begin
         sat_sub = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat_sub = diff[31:0];
      end
   endfunction

   function automatic time_type tmin(time_type a, time_type b);
      tmin = (a < b) ? a : b;
   endfunction

   function automatic time_type tmax(time_type a, time_type b);
      tmax = (a > b) ? a : b;
   endfunction

endpackage

// File: rtl/core/ist_mem.sv
// Two-bank entry memory: one write port, one registered read port.
module ist_mem #(
   parameter int AW = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  ist_pkg::entry_type    wr_entry,
   input  logic [AW-1:0]         rd_addr,
   output ist_pkg::entry_type    rd_entry
);
   import ist_pkg::*;

   entry_type mem_ff [2**AW];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// File: rtl/core/ist_ctrl.sv
// Sequencer and shared entry datapath: walks the table; add, remove, shift and lower rewrite it into the idle bank.
module ist_ctrl #(
   parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEF,
   parameter int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
   parameter int CW = $clog2(MAX_INTERVALS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_tuser,  // operation
   input  logic [127:0]          req_tdata,  // seg_start, seg_end, query_time, delta_time
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,  // found_valid
   output logic [71:0]           rsp_tdata,  // found_start, found_end, overflow, entry_count, pad
   input  logic [15:0]           min_overlap,
   output logic                  wr_en,
   output logic [IW:0]           wr_addr,
   output ist_pkg::entry_type    wr_entry,
   output logic [IW:0]           rd_addr,
   input  ist_pkg::entry_type    rd_entry
);
   import ist_pkg::*;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [2:0]    op_ff, op_in;
   time_type      s_ff, s_in, e_ff, e_in, q_ff, q_in, d_ff, d_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] held_ff, held_in, idx_ff, idx_in, cnt_ff, cnt_in;
   logic          pend_v_ff, pend_v_in;
   time_type      pend_s_ff, pend_s_in, pend_e_ff, pend_e_in;
   time_type      b_s_ff, b_s_in, b_e_ff, b_e_in;
   time_type      ns_ff, ns_in, ne_ff, ne_in;
   logic          ovf_ff, ovf_in, fv_ff, fv_in;
   time_type      fs_ff, fs_in, fe_ff, fe_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_user_ff, rsp_user_in;
   logic [71:0]   rsp_data_ff, rsp_data_in;

   logic          accept, bad_req, at_end, full, is_move, load_rsp;
   logic          push_req, merge_ok, go_b, go_done, go_flush;
   time_type      push_s, push_e, si, ei, rq_s, rq_e;
   time_type      cs, ce, mv_s, mv_e;
   logic signed [32:0] ov_len;
   logic [CW-1:0] cnt_m1;

   assign si = rd_entry.s;
   assign ei = rd_entry.e;
   assign rq_s = req_tdata[31:0];
   assign rq_e = req_tdata[63:32];
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign at_end = (idx_ff == held_ff);
   assign full = (held_ff == MAX_CNT);
   assign is_move = (op_ff == OP_SHIFT) || (op_ff == OP_LOWER);
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rd_addr = {bank_ff, idx_ff[IW-1:0]};
   assign cnt_m1 = cnt_ff - 1'b1;

   assign bad_req = (((req_tuser == OP_ADD) || (req_tuser == OP_REMOVE)) && (rq_s > rq_e))
                    || (req_tuser > OP_LOWER);

   // Entry evaluation on the shared datapath
   assign cs = tmax(si, s_ff);
   assign ce = tmin(ei, e_ff);
   assign ov_len = {ce[31], ce} - {cs[31], cs};
   assign mv_s = (op_ff == OP_SHIFT) ? sat_sub(si, d_ff) : si;
   assign mv_e = sat_sub(ei, d_ff);

   always_comb begin
      push_req = 1'b0;
      push_s = si;
      push_e = ei;
      b_s_in = b_s_ff;
      b_e_in = b_e_ff;
      phase_in = phase_ff;
      ns_in = ns_ff;
      ne_in = ne_ff;
      ovf_in = ovf_ff;
      fv_in = fv_ff;
      fs_in = fs_ff;
      fe_in = fe_ff;
      go_b = 1'b0;
      go_done = 1'b0;
      go_flush = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            phase_in = PH_BEFORE;
            ovf_in = 1'b0;
            fv_in = 1'b0;
            fs_in = NONE_START;
            fe_in = NONE_END;
         end
         ST_READ: begin
            if (at_end) begin
               unique case (op_ff)
                  OP_ADD: begin
                     unique case (phase_ff)
                        PH_BEFORE: begin
                           if (full) begin
                              ovf_in = 1'b1;
                              go_done = 1'b1;
                           end else begin
                              push_req = 1'b1;
                              push_s = s_ff;
                              push_e = e_ff;
                              go_flush = 1'b1;
                           end
                        end
                        PH_MERGE: begin
                           push_req = 1'b1;
                           push_s = ns_ff;
                           push_e = ne_ff;
                           go_flush = 1'b1;
                        end
                        default: go_flush = 1'b1;
                     endcase
                  end
                  OP_REMOVE, OP_SHIFT, OP_LOWER: go_flush = 1'b1;
                  default: go_done = 1'b1;
               endcase
            end
         end
         ST_EVAL: begin
            unique case (op_ff)
               OP_ADD: begin
                  unique case (phase_ff)
                     PH_BEFORE: begin
                        if (ei < s_ff) begin
                           push_req = 1'b1;
                        end else if (si <= e_ff) begin
                           ns_in = tmin(s_ff, si);
                           ne_in = tmax(e_ff, ei);
                           phase_in = PH_MERGE;
                        end else if (full) begin
                           ovf_in = 1'b1;
                           go_done = 1'b1;
                        end else begin
                           push_req = 1'b1;
                           push_s = s_ff;
                           push_e = e_ff;
                           b_s_in = si;
                           b_e_in = ei;
                           go_b = 1'b1;
                           phase_in = PH_AFTER;
                        end
                     end
                     PH_MERGE: begin
                        if (si <= e_ff) begin
                           ns_in = tmin(ns_ff, si);
                           ne_in = tmax(ne_ff, ei);
                        end else begin
                           push_req = 1'b1;
                           push_s = ns_ff;
                           push_e = ne_ff;
                           b_s_in = si;
                           b_e_in = ei;
                           go_b = 1'b1;
                           phase_in = PH_AFTER;
                        end
                     end
                     default: push_req = 1'b1;
                  endcase
               end
               OP_REMOVE: begin
                  if ((ei > s_ff) && (si <= e_ff) &&
                      (ov_len >= $signed({17'b0, min_overlap}))) begin
                     if (cs > si) begin
                        push_req = 1'b1;
                        push_e = cs;
                        if (ce < ei) begin
                           if (full) begin
                              ovf_in = 1'b1;
                           end else begin
                              b_s_in = ce;
                              b_e_in = ei;
                              go_b = 1'b1;
                           end
                        end
                     end else if (ce < ei) begin
                        push_req = 1'b1;
                        push_s = ce;
                     end
                  end else begin
                     push_req = 1'b1;
                  end
               end
               OP_SHIFT, OP_LOWER: begin
                  // drop entries that turned empty; keep ends in order
                  if (!(mv_s > mv_e)) begin
                     push_req = 1'b1;
                     push_s = mv_s;
                     push_e = (pend_v_ff && (mv_e < pend_e_ff)) ? pend_e_ff : mv_e;
                  end
               end
               default: begin
                  if (ei >= q_ff) begin
                     fv_in = 1'b1;
                     fs_in = si;
                     fe_in = ei;
                     go_done = 1'b1;
                  end
               end
            endcase
         end
         ST_EVAL2: begin
            push_req = 1'b1;
            push_s = b_s_ff;
            push_e = b_e_ff;
         end
         default: ;
      endcase
   end

   // Output list: hold the last pushed entry so move ops can merge into it
   always_comb begin
      merge_ok = is_move && pend_v_ff && (push_s <= pend_e_ff);
      pend_v_in = pend_v_ff;
      pend_s_in = pend_s_ff;
      pend_e_in = pend_e_ff;
      cnt_in = cnt_ff;
      held_in = held_ff;
      bank_in = bank_ff;
      idx_in = idx_ff;
      wr_en = 1'b0;
      wr_addr = {~bank_ff, cnt_m1[IW-1:0]};
      wr_entry = '{s: pend_s_ff, e: pend_e_ff};
      if (state_ff == ST_IDLE) begin
         cnt_in = '0;
         idx_in = '0;
         pend_v_in = 1'b0;
      end
      if ((state_ff == ST_READ) && !at_end) begin
         idx_in = idx_ff + 1'b1;
      end
      if (push_req) begin
         if (merge_ok) begin
            pend_s_in = tmin(pend_s_ff, push_s);
            pend_e_in = push_e;
         end else if (cnt_ff < MAX_CNT) begin
            wr_en = pend_v_ff;
            pend_v_in = 1'b1;
            pend_s_in = push_s;
            pend_e_in = push_e;
            cnt_in = cnt_ff + 1'b1;
         end
      end
      if (state_ff == ST_FLUSH) begin
         wr_en = pend_v_ff;
         held_in = cnt_ff;
         bank_in = ~bank_ff;
      end
   end

   always_comb begin
      op_in = op_ff;
      s_in = s_ff;
      e_in = e_ff;
      q_in = q_ff;
      d_in = d_ff;
      if (accept) begin
         op_in = req_tuser;
         s_in = rq_s;
         e_in = rq_e;
         q_in = req_tdata[95:64];
         d_in = req_tdata[127:96];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = bad_req ? ST_DONE : ST_READ;
         ST_READ: begin
            if (go_done) state_in = ST_DONE;
            else if (go_flush) state_in = ST_FLUSH;
            else if (!at_end) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (go_done) state_in = ST_DONE;
            else if (go_b) state_in = ST_EVAL2;
            else state_in = ST_READ;
         end
         ST_EVAL2: state_in = ST_READ;
         ST_FLUSH: state_in = ST_DONE;
         ST_DONE:  if (load_rsp) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in = rsp_user_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_user_in = fv_ff;
         rsp_data_in = {1'b0, 6'(held_ff), ovf_ff, fe_ff, fs_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff <= '0;
         bank_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         bank_ff <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff <= phase_in;
      op_ff <= op_in;
      s_ff <= s_in;
      e_ff <= e_in;
      q_ff <= q_in;
      d_ff <= d_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      pend_v_ff <= pend_v_in;
      pend_s_ff <= pend_s_in;
      pend_e_ff <= pend_e_in;
      b_s_ff <= b_s_in;
      b_e_ff <= b_e_in;
      ns_ff <= ns_in;
      ne_ff <= ne_in;
      ovf_ff <= ovf_in;
      fv_ff <= fv_in;
      fs_ff <= fs_in;
      fe_ff <= fe_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tdata = rsp_data_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= MAX_CNT) else $error("held count above capacity");
   a_wr_idle_bank: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr[IW] != bank_ff)) else $error("write into the live bank");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff <= MAX_CNT)) else $error("output count overrun");
   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> ($past(state_ff) == ST_FLUSH))
      else $error("bank changed outside commit");

endmodule

// File: rtl/core/interval_set_table.sv
// Top level of the interval set table: config register, sequencer and entry memory.
// Each request walks the held entries, with an extra step per inserted or split entry,
// then commits and responds; find stops at the first hit.
// One request at a time: req_tready is high only while idle, and the walk is paced
// by the single read port of the entry memory and the shared compare unit.
// Reset: table empty, min_overlap_length = 1; memory contents need no clearing.
module interval_set_table #(
   parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    req_tuser,  // operation
   input  logic [127:0]  req_tdata,  // seg_start, seg_end, query_time, delta_time
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic          rsp_tuser,  // found_valid
   output logic [71:0]   rsp_tdata,  // found_start, found_end, overflow, entry_count, pad
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [15:0]   csr_data    // min_overlap_length
);
   import ist_pkg::*;

   localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CW = $clog2(MAX_INTERVALS + 1);

   logic [15:0] min_overlap_ff, min_overlap_in;
   logic        wr_en;
   logic [IW:0] wr_addr, rd_addr;
   entry_type   wr_entry, rd_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      min_overlap_in = min_overlap_ff;
      if (csr_valid && csr_ready) begin
         min_overlap_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_overlap_ff <= 16'd1;
      end else begin
         min_overlap_ff <= min_overlap_in;
      end
   end

   ist_ctrl #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .IW            (IW),
      .CW            (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .min_overlap (min_overlap_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_entry    (wr_entry),
      .rd_addr     (rd_addr),
      .rd_entry    (rd_entry)
   );

   ist_mem #(
      .AW (IW + 1)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

endmodule
